/* rtl/core/tksd_pkg.sv */
// Shared types, codes and constants of the terminal key sequence decoder.
package tksd_pkg;

    localparam int PARAM_BITS_DEF = 8;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam logic [3:0] KEY_ESC   = 4'd0;
    localparam logic [3:0] KEY_ENTER = 4'd1;
    localparam logic [3:0] KEY_CHAR  = 4'd2;
    localparam logic [3:0] KEY_UP    = 4'd3;
    localparam logic [3:0] KEY_DOWN  = 4'd4;
    localparam logic [3:0] KEY_RIGHT = 4'd5;
    localparam logic [3:0] KEY_LEFT  = 4'd6;
    localparam logic [3:0] KEY_HOME  = 4'd7;
    localparam logic [3:0] KEY_END   = 4'd8;
    localparam logic [3:0] KEY_PGUP  = 4'd9;
    localparam logic [3:0] KEY_PGDN  = 4'd10;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SS3    = 8'h4F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_HOME   = 8'h48;
    localparam logic [7:0] CH_END    = 8'h46;

    localparam int TP_HOME_A = 1;
    localparam int TP_HOME_B = 7;
    localparam int TP_END_A  = 4;
    localparam int TP_END_B  = 8;
    localparam int TP_PGUP   = 5;
    localparam int TP_PGDN   = 6;

    typedef struct packed {
        logic [3:0] key_code;
        logic [6:0] key_char;
        logic       modified;
        logic       last;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

endpackage

/* rtl/core/tksd_if.sv */
// Valid/ready channel interfaces for input beats and result beats.
interface tksd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;

    modport source (output valid, output req_type, output byte_value, input ready);
    modport sink (input valid, input req_type, input byte_value, output ready);
endinterface

interface tksd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_code;
    logic [6:0] key_char;
    logic       modified;
    logic       last;

    modport source (output valid, output key_code, output key_char, output modified,
                    output last, input ready);
    modport sink (input valid, input key_code, input key_char, input modified,
                  input last, output ready);
endinterface

/* rtl/core/tksd_decode.sv */
// Decoder state registers and single-pass decode of one input beat.
module tksd_decode #(
    parameter int PARAM_BITS = tksd_pkg::PARAM_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              req_type,
    input  logic [7:0]        byte_value,
    output tksd_pkg::push_t   push
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ESC  = 3'b010,
        PH_SEQ  = 3'b100
    } phase_t;

    typedef struct packed {
        logic          esc;
        logic          hit;
        tksd_pkg::res_t res;
    } idle_t;

    localparam int VW = PARAM_BITS + 4;
    localparam logic [VW-1:0] VMAX = VW'({PARAM_BITS{1'b1}});

    phase_t                phase_reg, phase_next;
    logic [PARAM_BITS-1:0] fp_reg, fp_next;
    logic                  closed_reg, closed_next;
    logic                  sep_reg, sep_next;

    logic [VW-1:0]         fp_ext;
    logic [VW-1:0]         fp_mac;
    idle_t                 idl;
    tksd_pkg::push_t       p;
    logic                  found;
    logic [3:0]            fcode;

    function automatic idle_t idle_key(input logic [7:0] b);
        idle_t r;
        r = '0;
        if (b == tksd_pkg::CH_ESC) begin
            r.esc = 1'b1;
        end else if (b == tksd_pkg::CH_CR || b == tksd_pkg::CH_LF) begin
            r.hit = 1'b1;
            r.res.key_code = tksd_pkg::KEY_ENTER;
        end else if (b >= tksd_pkg::CH_SPACE && b < tksd_pkg::CH_DEL) begin
            r.hit = 1'b1;
            r.res.key_code = tksd_pkg::KEY_CHAR;
            r.res.key_char = b[6:0];
        end
        return r;
    endfunction

    assign idl    = idle_key(byte_value);
    assign fp_ext = VW'(fp_reg);
    assign fp_mac = (fp_ext << 3) + (fp_ext << 1) + VW'(byte_value - tksd_pkg::CH_ZERO);

    // final byte lookup
    always_comb
    begin
        found = 1'b1;
        fcode = tksd_pkg::KEY_ESC;
        case (byte_value)
            tksd_pkg::CH_UP:    fcode = tksd_pkg::KEY_UP;
            tksd_pkg::CH_DOWN:  fcode = tksd_pkg::KEY_DOWN;
            tksd_pkg::CH_RIGHT: fcode = tksd_pkg::KEY_RIGHT;
            tksd_pkg::CH_LEFT:  fcode = tksd_pkg::KEY_LEFT;
            tksd_pkg::CH_HOME:  fcode = tksd_pkg::KEY_HOME;
            tksd_pkg::CH_END:   fcode = tksd_pkg::KEY_END;
            tksd_pkg::CH_TILDE:
            begin
                case (fp_reg) inside
                    PARAM_BITS'(tksd_pkg::TP_HOME_A), PARAM_BITS'(tksd_pkg::TP_HOME_B):
                        fcode = tksd_pkg::KEY_HOME;
                    PARAM_BITS'(tksd_pkg::TP_END_A), PARAM_BITS'(tksd_pkg::TP_END_B):
                        fcode = tksd_pkg::KEY_END;
                    PARAM_BITS'(tksd_pkg::TP_PGUP):
                        fcode = tksd_pkg::KEY_PGUP;
                    PARAM_BITS'(tksd_pkg::TP_PGDN):
                        fcode = tksd_pkg::KEY_PGDN;
                    default:
                        found = 1'b0;
                endcase
            end
            default: found = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fp_next     = fp_reg;
        closed_next = closed_reg;
        sep_next    = sep_reg;
        p           = '0;
        if (fire) begin
            if (req_type == tksd_pkg::REQ_TIMEOUT) begin
                if (phase_reg == PH_ESC) begin
                    p.v0 = 1'b1;
                    p.r0.key_code = tksd_pkg::KEY_ESC;
                end
                phase_next  = PH_IDLE;
                fp_next     = '0;
                closed_next = 1'b0;
                sep_next    = 1'b0;
            end else begin
                case (phase_reg)
                    PH_ESC:
                    begin
                        fp_next     = '0;
                        closed_next = 1'b0;
                        sep_next    = 1'b0;
                        if (byte_value == tksd_pkg::CH_LBRACK ||
                            byte_value == tksd_pkg::CH_SS3) begin
                            phase_next = PH_SEQ;
                        end else begin
                            p.v0 = 1'b1;
                            p.r0.key_code = tksd_pkg::KEY_ESC;
                            p.v1 = idl.hit;
                            p.r1 = idl.res;
                            phase_next = idl.esc ? PH_ESC : PH_IDLE;
                        end
                    end
                    PH_SEQ:
                    begin
                        if (byte_value >= tksd_pkg::CH_ZERO && byte_value <= tksd_pkg::CH_NINE) begin
                            if (!closed_reg) begin
                                fp_next = (fp_mac > VMAX) ? {PARAM_BITS{1'b1}}
                                                          : fp_mac[PARAM_BITS-1:0];
                            end
                        end else if (byte_value == tksd_pkg::CH_SEMI) begin
                            closed_next = 1'b1;
                            sep_next    = 1'b1;
                        end else begin
                            p.v0 = found;
                            p.r0.key_code = fcode;
                            p.r0.modified = sep_reg;
                            phase_next  = PH_IDLE;
                            fp_next     = '0;
                            closed_next = 1'b0;
                            sep_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        p.v0 = idl.hit;
                        p.r0 = idl.res;
                        phase_next = idl.esc ? PH_ESC : PH_IDLE;
                    end
                endcase
            end
        end
        // tag the final result of this beat
        p.r0.last = !p.v1;
        p.r1.last = 1'b1;
    end

    assign push = p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_IDLE;
            fp_reg     <= '0;
            closed_reg <= 1'b0;
            sep_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            fp_reg     <= fp_next;
            closed_reg <= closed_next;
            sep_reg    <= sep_next;
        end
    end

endmodule

/* rtl/core/tksd_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per beat.
module tksd_res_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tksd_pkg::push_t                push,
    input  logic                           pop_ready,
    output logic                           room,
    output logic                           head_valid,
    output tksd_pkg::res_t                 head,
    output logic [tksd_pkg::RQ_CNT_W-1:0]  count
);

    localparam int PW = tksd_pkg::RQ_PTR_W;
    localparam int CW = tksd_pkg::RQ_CNT_W;

    tksd_pkg::res_t entry_reg [tksd_pkg::RQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           pop;
    logic [CW-1:0]  push_n;

    assign pop         = (count_reg != '0) && pop_ready;
    assign push_n      = CW'(push.v0) + CW'(push.v1);
    assign wr_ptr_next = wr_ptr_reg + PW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + push_n - CW'(pop);

    assign room       = count_reg <= CW'(tksd_pkg::RQ_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.v0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            entry_reg[wr_ptr_reg + PW'(push.v0)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/terminal_key_sequence_decoder.sv */
// Terminal key sequence decoder top level.
//
// in_ch carries one beat per terminal byte (req_type 0) or input-gap timeout
// (req_type 1). out_ch carries decoded keys: key_code, key_char for
// character keys, modified when the control sequence held a separator, and
// last on the final key caused by one input beat. One input beat yields zero,
// one or two output beats.
// The first key of an input beat is written into the result queue when the
// beat is taken and is offered from the queue head; a second key follows it.
// Throughput: one input beat per cycle while the queue has room and one
// output beat per cycle while out_ch is ready; the decode is a single pass
// between the state registers and a four-entry result queue. in_ch.ready is
// high while the queue has room for two results, so input keeps flowing while
// earlier keys wait. When out_ch stalls, queued keys hold and input stops once
// the queue cannot take two more results.
// Reset clears the decoder to idle with no partial sequence and empties
// the queue; the block takes input in the first cycle after reset.
module terminal_key_sequence_decoder #(
    parameter int PARAM_BITS = tksd_pkg::PARAM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tksd_in_if.sink     in_ch,
    tksd_out_if.source  out_ch
);

    logic                          fire;
    logic                          room;
    logic                          head_valid;
    tksd_pkg::res_t                head;
    tksd_pkg::push_t               push;
    logic [tksd_pkg::RQ_CNT_W-1:0] count;

    assign in_ch.ready = room;
    assign fire        = in_ch.valid && room;

    tksd_decode #(
        .PARAM_BITS (PARAM_BITS)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req_type   (in_ch.req_type),
        .byte_value (in_ch.byte_value),
        .push       (push)
    );

    tksd_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (out_ch.ready),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .count      (count)
    );

    assign out_ch.valid    = head_valid;
    assign out_ch.key_code = head.key_code;
    assign out_ch.key_char = head.key_char;
    assign out_ch.modified = head.modified;
    assign out_ch.last     = head.last;

`ifndef NO_ASSERTIONS
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result pushed without a first");

    a_timeout_single: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_ch.req_type == tksd_pkg::REQ_TIMEOUT) |-> !push.v1)
        else $error("timeout produced two results");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |=> out_ch.valid)
        else $error("pushed result not offered on output");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count <= tksd_pkg::RQ_CNT_W'(tksd_pkg::RQ_DEPTH))
        else $error("result queue overflow");
`endif

endmodule
